/* rtl/tdu_pkg.sv */
// Shared types, codes and constants of the 2-bit DNA unpacker.
`default_nettype none

package tdu_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  localparam logic [7:0] CHAR_T       = 8'h54;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_N       = 8'h4E;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  typedef enum logic [1:0] {
    REQ_LOAD_UNKNOWN = 2'd0,
    REQ_LOAD_MASK    = 2'd1,
    REQ_BYTE         = 2'd2,
    REQ_CLEAR        = 2'd3
  } req_type_e;

  typedef struct packed {
    logic latch;
    logic load;
    logic clear;
    logic rewind;
    logic start_byte;
    logic seek;
    logic step_k;
    logic done_byte;
    logic emit_base;
    logic emit_error;
  } dp_cmd_t;

  typedef struct packed {
    req_type_e req_type;
    logic      table_full;
    logic      byte_bad;
    logic      in_region;
    logic      need_seek;
    logic      last_emit;
    logic      k_last;
    logic      out_free;
  } dp_status_t;

  function automatic logic [7:0] base_char_of(input logic [1:0] code);
    logic [7:0] ch;
    unique case (code)
      2'd0:    ch = CHAR_T;
      2'd1:    ch = CHAR_C;
      2'd2:    ch = CHAR_A;
      default: ch = CHAR_G;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/tdu_if.sv */
// Valid/ready channel interfaces for requests and decoded bases.
`default_nettype none

interface tdu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] interval_start;
  logic [31:0] interval_end;
  logic [7:0]  packed_byte;
  logic        last_byte;

  modport source (output valid, req_type, interval_start, interval_end, packed_byte,
                  last_byte, input ready);
  modport sink (input valid, req_type, interval_start, interval_end, packed_byte,
                last_byte, output ready);
endinterface

interface tdu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       last;
  logic       error;

  modport source (output valid, base_char, last, error, input ready);
  modport sink (input valid, base_char, last, error, output ready);
endinterface

`default_nettype wire

/* rtl/twobit_dna_unpacker_core.sv */
// Top level of the 2-bit DNA unpacker: controller, datapath and assertions.
//
// channel  dir  transfer carries
// req_i    in   req_type, interval_start, interval_end, packed_byte, last_byte
// res_o    out  base_char, last, error
// cfg_*    in   region_start (index 0), region_end (index 1), one write per cycle
//
// Load, clear and a rejected byte go through the dispatch state before ready rises again.
// A packed byte walks its base positions (four, fewer when the region ends inside the
// byte), with a seek whenever a cursor must step; one seek steps each cursor that must,
// and the table memories give one entry a cycle.
// Reset empties both tables (fill counts only) and rewinds the stream; no clearing pass.
// A stalled result holds the walk only when the next base needs the output register.
`default_nettype none

module twobit_dna_unpacker_core #(
  parameter int unsigned MAX_INTERVALS = tdu_pkg::MAX_INTERVALS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  tdu_req_if.sink                       req_i,
  tdu_res_if.source                     res_o
);

  import tdu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdu_datapath #(.MAX_INTERVALS(MAX_INTERVALS)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_i.req_type),
    .interval_start_i (req_i.interval_start),
    .interval_end_i   (req_i.interval_end),
    .packed_byte_i    (req_i.packed_byte),
    .last_byte_i      (req_i.last_byte),
    .cmd_i            (cmd),
    .status_o         (status),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .base_char_o      (res_o.base_char),
    .last_o           (res_o.last),
    .error_o          (res_o.error)
  );

  // an accepted item is always dispatched before the next one is taken
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready
  ) else $error("ready high right after a transfer");

  a_emit_needs_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_base || cmd.emit_error) |-> status.out_free
  ) else $error("result emitted into an occupied output register");

  a_one_emit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.emit_base, cmd.emit_error, cmd.seek, cmd.load})
  ) else $error("conflicting datapath commands");

  a_error_shape: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.error) |-> (res_o.last && (res_o.base_char == CHAR_NONE))
  ) else $error("error result without last or with a character");

endmodule

`default_nettype wire

/* rtl/tdu_table.sv */
// Interval table: entry memory, fill count and walking cursor.
`default_nettype none

module tdu_table #(
  parameter int unsigned MAX_INTERVALS = tdu_pkg::MAX_INTERVALS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        rewind_i,
  input  logic        wr_i,
  input  logic        seek_i,
  input  logic [31:0] start_i,
  input  logic [31:0] end_i,
  input  logic [31:0] pos_i,
  output logic        full_o,
  output logic        step_o,
  output logic        hit_o
);

  localparam int unsigned CntW  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AddrW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] stop;
  } entry_t;

  entry_t mem [MAX_INTERVALS];
  entry_t rd_q;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic            valid;

  assign full_o = (count_q == CntW'(MAX_INTERVALS));
  assign valid  = (cursor_q < count_q);
  assign step_o = valid && (rd_q.stop <= pos_i);
  assign hit_o  = valid && (rd_q.first <= pos_i) && (pos_i < rd_q.stop);

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_i) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    if (rewind_i) begin
      cursor_d = '0;
    end else if (seek_i && step_o) begin
      cursor_d = cursor_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // read follows the next cursor, missing a same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[count_q[AddrW-1:0]] <= '{first: start_i, stop: end_i};
    end
    rd_q <= mem[cursor_d[AddrW-1:0]];
  end

endmodule

`default_nettype wire

/* rtl/tdu_datapath.sv */
// Datapath: region registers, item latch, byte checks, base decode, output register.
`default_nettype none

module tdu_datapath #(
  parameter int unsigned MAX_INTERVALS = tdu_pkg::MAX_INTERVALS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  input  logic [1:0]                   req_type_i,
  input  logic [31:0]                  interval_start_i,
  input  logic [31:0]                  interval_end_i,
  input  logic [7:0]                   packed_byte_i,
  input  logic                         last_byte_i,
  input  tdu_pkg::dp_cmd_t             cmd_i,
  output tdu_pkg::dp_status_t          status_o,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output logic [7:0]                   base_char_o,
  output logic                         last_o,
  output logic                         error_o
);

  import tdu_pkg::*;

  logic [31:0] region_start_q, region_end_q;
  req_type_e   item_type_q;
  logic [31:0] ivs_q, ive_q;
  logic [7:0]  byte_q;
  logic        is_last_q;
  logic [31:0] next_pos_q;
  logic        first_pending_q;
  logic [29:0] base_idx_q;
  logic [1:0]  k_q;
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        out_last_q, out_err_q;

  logic [32:0] end_plus3;
  logic [30:0] end_idx;
  logic [29:0] idx;
  logic [30:0] idx_next;
  logic [31:0] pos;
  logic [1:0]  code;
  logic [7:0]  ch;
  logic        unk_full, unk_step, unk_hit;
  logic        msk_full, msk_step, msk_hit;
  logic        is_unknown;
  logic        rewind_all;

  assign is_unknown = (item_type_q == REQ_LOAD_UNKNOWN);
  assign rewind_all = cmd_i.rewind || (cmd_i.done_byte && is_last_q);

  assign end_plus3 = {1'b0, region_end_q} + 33'd3;
  assign end_idx   = end_plus3[32:2];
  assign idx       = first_pending_q ? region_start_q[31:2] : next_pos_q[31:2];
  assign idx_next  = {1'b0, idx} + 31'd1;
  assign pos       = {base_idx_q, k_q};

  tdu_table #(.MAX_INTERVALS(MAX_INTERVALS)) u_unknown (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cmd_i.clear),
    .rewind_i (rewind_all),
    .wr_i     (cmd_i.load && is_unknown),
    .seek_i   (cmd_i.seek),
    .start_i  (ivs_q),
    .end_i    (ive_q),
    .pos_i    (pos),
    .full_o   (unk_full),
    .step_o   (unk_step),
    .hit_o    (unk_hit)
  );

  tdu_table #(.MAX_INTERVALS(MAX_INTERVALS)) u_mask (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cmd_i.clear),
    .rewind_i (rewind_all),
    .wr_i     (cmd_i.load && !is_unknown),
    .seek_i   (cmd_i.seek),
    .start_i  (ivs_q),
    .end_i    (ive_q),
    .pos_i    (pos),
    .full_o   (msk_full),
    .step_o   (msk_step),
    .hit_o    (msk_hit)
  );

  always_comb begin
    case (k_q)
      2'd0:    code = byte_q[7:6];
      2'd1:    code = byte_q[5:4];
      2'd2:    code = byte_q[3:2];
      default: code = byte_q[1:0];
    endcase
    ch = unk_hit ? CHAR_N : base_char_of(code);
    if (msk_hit) begin
      ch = ch + CASE_OFFSET;
    end
  end

  always_comb begin
    status_o.req_type   = item_type_q;
    status_o.table_full = is_unknown ? unk_full : msk_full;
    status_o.byte_bad   = (region_end_q < region_start_q)
                       || ({1'b0, region_start_q[31:2]} >= end_idx)
                       || (idx_next > end_idx)
                       || ((idx_next == end_idx) != is_last_q);
    status_o.in_region  = (pos >= region_start_q) && (pos < region_end_q);
    status_o.need_seek  = unk_step || msk_step;
    status_o.last_emit  = (k_q == 2'd3) || (({1'b0, pos} + 33'd1) == {1'b0, region_end_q});
    status_o.k_last     = (k_q == 2'd3);
    status_o.out_free   = !out_valid_q || res_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q  <= '0;
      region_end_q    <= '0;
      next_pos_q      <= '0;
      first_pending_q <= 1'b1;
      k_q             <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGION_START: region_start_q <= cfg_wdata_i;
          CFG_REGION_END:   region_end_q   <= cfg_wdata_i;
          default:          ;
        endcase
      end
      if (rewind_all) begin
        next_pos_q      <= region_start_q;
        first_pending_q <= 1'b1;
      end else if (cmd_i.done_byte) begin
        next_pos_q      <= {base_idx_q + 30'd1, 2'b00};
        first_pending_q <= 1'b0;
      end
      if (cmd_i.start_byte) begin
        k_q <= '0;
      end else if (cmd_i.step_k) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.emit_base || cmd_i.emit_error) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_type_q <= req_type_e'(req_type_i);
      ivs_q       <= interval_start_i;
      ive_q       <= interval_end_i;
      byte_q      <= packed_byte_i;
      is_last_q   <= last_byte_i;
    end
    if (cmd_i.start_byte) begin
      base_idx_q <= idx;
    end
    if (cmd_i.emit_base) begin
      out_char_q <= ch;
      out_last_q <= status_o.last_emit;
      out_err_q  <= 1'b0;
    end else if (cmd_i.emit_error) begin
      out_char_q <= CHAR_NONE;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  assign res_valid_o = out_valid_q;
  assign base_char_o = out_char_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;

endmodule

`default_nettype wire

/* rtl/tdu_ctrl.sv */
// Controller: sequences loads, clears and the per-base walk of a packed byte.
`default_nettype none

module tdu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  tdu_pkg::dp_status_t status_i,
  output tdu_pkg::dp_cmd_t    cmd_o
);

  import tdu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.req_type) inside
          REQ_LOAD_UNKNOWN, REQ_LOAD_MASK: begin
            if (!status_i.table_full) begin
              cmd_o.load = 1'b1;
              state_d    = ST_IDLE;
            end else if (status_i.out_free) begin
              cmd_o.emit_error = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          REQ_CLEAR: begin
            cmd_o.clear  = 1'b1;
            cmd_o.rewind = 1'b1;
            state_d      = ST_IDLE;
          end
          default: begin
            if (!status_i.byte_bad) begin
              cmd_o.start_byte = 1'b1;
              state_d          = ST_WALK;
            end else if (status_i.out_free) begin
              cmd_o.rewind     = 1'b1;
              cmd_o.emit_error = 1'b1;
              state_d          = ST_IDLE;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (!status_i.in_region) begin
          if (status_i.k_last) begin
            cmd_o.done_byte = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.step_k = 1'b1;
          end
        end else if (status_i.need_seek) begin
          cmd_o.seek = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit_base = 1'b1;
          if (status_i.last_emit) begin
            cmd_o.done_byte = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.step_k = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* tb/twobit_dna_unpacker_core_tb.sv */
// Testbench for twobit_dna_unpacker_core: directed and random streams with a base predictor.
`timescale 1ns / 100ps

module twobit_dna_unpacker_core_tb;
  import tdu_pkg::*;

  localparam int TBL_DEPTH       = MAX_INTERVALS_DEF;
  localparam int TBL_UNKNOWN     = 0;
  localparam int TBL_MASK        = 1;
  localparam int SETTLE_CYCLES   = 2 * TBL_DEPTH + 16;
  localparam int RES_HOLD_CYCLES = 120;
  localparam int TIMEOUT_NS      = 4_000_000;
  localparam logic [31:0] BASE_CODES = {CHAR_G, CHAR_A, CHAR_C, CHAR_T};

  typedef struct {
    req_type_e   kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  data;
    logic        last;
  } req_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } base_res_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  tdu_req_if req_if ();
  tdu_res_if res_if ();

  twobit_dna_unpacker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // predictor state
  logic [31:0] rgn_start = '0;
  logic [31:0] rgn_end = '0;
  logic [31:0] iv_lo [2][TBL_DEPTH];
  logic [31:0] iv_hi [2][TBL_DEPTH];
  int          iv_count [2] = '{0, 0};
  int          iv_cursor [2] = '{0, 0};
  logic [31:0] next_pos = '0;
  bit          fresh_region = 1'b1;

  base_res_t expected_bases [$];
  int        err_count = 0;
  int        items_sent = 0;
  bit        src_idle_en = 1'b1;
  bit        sink_idle_en = 1'b1;
  bit        res_hold = 1'b0;
  int        res_stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("twobit_dna_unpacker_core test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    err_count++;
  endtask

  function automatic void rewind_stream();
    iv_cursor[TBL_UNKNOWN] = 0;
    iv_cursor[TBL_MASK] = 0;
    next_pos = rgn_start;
    fresh_region = 1'b1;
  endfunction

  function automatic bit interval_hit(input int tbl, input logic [63:0] pos);
    while (iv_cursor[tbl] < iv_count[tbl] && {32'd0, iv_hi[tbl][iv_cursor[tbl]]} <= pos)
      iv_cursor[tbl]++;
    if (iv_cursor[tbl] >= iv_count[tbl]) return 1'b0;
    return {32'd0, iv_lo[tbl][iv_cursor[tbl]]} <= pos &&
           pos < {32'd0, iv_hi[tbl][iv_cursor[tbl]]};
  endfunction

  function automatic void predict_bases(input req_item_t it);
    int          tbl;
    logic [63:0] s, e, first_idx, end_idx, idx, base_pos, pos;
    logic [1:0]  code;
    logic [7:0]  ch;
    base_res_t   r;
    base_res_t   res_q [$];
    case (it.kind) inside
      REQ_LOAD_UNKNOWN, REQ_LOAD_MASK: begin
        tbl = (it.kind == REQ_LOAD_UNKNOWN) ? TBL_UNKNOWN : TBL_MASK;
        if (iv_count[tbl] >= TBL_DEPTH) begin
          expected_bases.push_back('{CHAR_NONE, 1'b1, 1'b1});
        end else begin
          iv_lo[tbl][iv_count[tbl]] = it.lo;
          iv_hi[tbl][iv_count[tbl]] = it.hi;
          iv_count[tbl]++;
        end
      end
      REQ_CLEAR: begin
        iv_count[TBL_UNKNOWN] = 0;
        iv_count[TBL_MASK] = 0;
        rewind_stream();
      end
      default: begin
        s = {32'd0, rgn_start};
        e = {32'd0, rgn_end};
        first_idx = s >> 2;
        end_idx = (e + 64'd3) >> 2;
        idx = fresh_region ? first_idx : ({32'd0, next_pos} >> 2);
        if (e < s || end_idx <= first_idx || idx + 1 > end_idx ||
            ((idx + 1 == end_idx) != it.last)) begin
          rewind_stream();
          expected_bases.push_back('{CHAR_NONE, 1'b1, 1'b1});
        end else begin
          base_pos = idx << 2;
          for (int k = 0; k < 4; k++) begin
            pos = base_pos + k;
            if (pos >= s && pos < e) begin
              code = 2'(it.data >> (6 - 2 * k));
              ch = BASE_CODES[8 * code +: 8];
              if (interval_hit(TBL_UNKNOWN, pos)) ch = CHAR_N;
              if (interval_hit(TBL_MASK, pos)) ch = ch + CASE_OFFSET;
              r.ch = ch;
              r.last = 1'b0;
              r.err = 1'b0;
              res_q.push_back(r);
            end
          end
          if (res_q.size() > 0) res_q[res_q.size() - 1].last = 1'b1;
          foreach (res_q[i]) expected_bases.push_back(res_q[i]);
          if (it.last) begin
            rewind_stream();
          end else begin
            fresh_region = 1'b0;
            next_pos = base_pos[31:0] + 32'd4;
          end
        end
      end
    endcase
  endfunction

  // result side: random stall bursts, plus the long hold when requested
  always @(posedge clk_i) begin
    if (res_hold) begin
      res_if.ready <= 1'b0;
    end else if (res_stall_left > 0) begin
      res_stall_left--;
      res_if.ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      res_stall_left = $urandom_range(0, 8);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_bases
    base_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_bases.size() == 0) begin
        report_mismatch($sformatf("unexpected result: char %h last %b error %b",
                                  res_if.base_char, res_if.last, res_if.error));
      end else begin
        want = expected_bases.pop_front();
        if (res_if.base_char !== want.ch)
          report_mismatch($sformatf("base_char %h, expected %h", res_if.base_char, want.ch));
        if (res_if.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", res_if.last, want.last));
        if (res_if.error !== want.err)
          report_mismatch($sformatf("error %b, expected %b", res_if.error, want.err));
      end
    end
  end

  task automatic send_item(input req_type_e kind, input logic [31:0] lo, input logic [31:0] hi,
                           input logic [7:0] data, input logic last);
    req_item_t it;
    int        gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.interval_start <= lo;
    req_if.interval_end <= hi;
    req_if.packed_byte <= data;
    req_if.last_byte <= last;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    it = '{kind, lo, hi, data, last};
    predict_bases(it);
    items_sent++;
  endtask

  task automatic load_interval(input req_type_e kind, input logic [31:0] lo,
                               input logic [31:0] hi);
    send_item(kind, lo, hi, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    send_item(REQ_BYTE, $urandom, $urandom, data, last);
  endtask

  task automatic send_clear();
    send_item(REQ_CLEAR, $urandom, $urandom, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    send_item(req_type_e'($urandom_range(0, 3)), $urandom, $urandom, 8'($urandom),
              1'($urandom));
  endtask

  // sender pauses until all results are back, then lets the block settle
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (expected_bases.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_region(input logic [31:0] s, input logic [31:0] e);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_REGION_START;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_idx_i <= CFG_REGION_END;
    cfg_wdata_i <= e;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rgn_start = s;
    rgn_end = e;
  endtask

  task automatic load_sorted(input req_type_e kind, input logic [31:0] from, input int count,
                             input int max_step);
    logic [31:0] p, lo, hi;
    p = from;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = p + $urandom_range(0, max_step);
        hi = lo + $urandom_range(0, max_step);
        p = hi;
      end
      load_interval(kind, lo, hi);
    end
  endtask

  // bytes for the configured region; broken runs cut short, drop the last flag or add an extra byte
  task automatic stream_region(input bit allow_broken);
    logic [63:0] s, e;
    int          n, mode, cut;
    s = {32'd0, rgn_start};
    e = {32'd0, rgn_end};
    n = (e < s) ? 1 : int'(((e + 64'd3) >> 2) - (s >> 2));
    if (n == 0) n = 1;
    mode = allow_broken ? $urandom_range(0, 7) : 7;
    cut = $urandom_range(0, n - 1);
    for (int b = 0; b < n; b++) begin
      if (allow_broken && $urandom_range(0, 24) == 0) send_noise();
      if (mode == 0 && b == cut) begin
        send_byte(8'($urandom), 1'b1);
        break;
      end
      send_byte(8'($urandom), (b == n - 1) && mode != 1);
    end
    if (mode == 2) send_byte(8'($urandom), 1'($urandom));
  endtask

  task automatic test_basic_decode();
    write_region(32'd1, 32'd14);
    send_clear();
    load_interval(REQ_LOAD_UNKNOWN, 32'd3, 32'd6);
    load_interval(REQ_LOAD_UNKNOWN, 32'd9, 32'd8);
    load_interval(REQ_LOAD_MASK, 32'd5, 32'd11);
    send_byte(8'h1B, 1'b0);
    send_byte(8'hE4, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_count_errors();
    send_byte(8'h6C, 1'b1);
    send_byte(8'h93, 1'b0);
    send_byte(8'h27, 1'b0);
    wait_drain();
    write_region(32'd0, 32'd4);
    send_byte(8'hC6, 1'b1);
    send_byte(8'h39, 1'b0);
    wait_drain();
    write_region(32'd8, 32'd8);
    send_byte(8'hA5, 1'b1);
    wait_drain();
    write_region(32'd5, 32'd5);
    send_byte(8'h5A, 1'b1);
    wait_drain();
    write_region(32'd20, 32'd10);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_region_extremes();
    wait_drain();
    write_region(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    load_interval(REQ_LOAD_UNKNOWN, 32'hFFFF_FFF2, 32'hFFFF_FFF7);
    load_interval(REQ_LOAD_MASK, 32'hFFFF_FFF4, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_drain();
    write_region(32'h0000_0000, 32'hFFFF_FFFF);
    send_byte(8'h1B, 1'b0);
    send_byte(8'hE4, 1'b1);
    wait_drain();
    write_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_table_overflow();
    wait_drain();
    write_region(32'd2, 32'd62);
    send_clear();
    load_sorted(REQ_LOAD_UNKNOWN, 32'd0, TBL_DEPTH + 2, 1);
    load_sorted(REQ_LOAD_MASK, 32'd1, 6, 1);
    fork
      begin
        res_hold <= 1'b1;
        repeat (RES_HOLD_CYCLES) @(posedge clk_i);
        res_hold <= 1'b0;
      end
    join_none
    stream_region(1'b0);
  endtask

  task automatic test_random_regions(input int target);
    int          first_item;
    logic [31:0] s, e;
    first_item = items_sent;
    while (items_sent - first_item < target) begin
      if (src_idle_en && items_sent - first_item > (target * 2) / 3) begin
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
      end
      wait_drain();
      case ($urandom_range(0, 11))
        0: begin
          s = 32'hFFFF_FFFF - $urandom_range(0, 30);
          e = s + $urandom_range(0, 32'hFFFF_FFFF - s);
        end
        1: begin
          s = $urandom_range(8, 32'hFFFF_FFFF);
          e = s - $urandom_range(1, 8);
        end
        2: begin
          s = $urandom;
          e = s;
        end
        3, 4: begin
          s = $urandom_range(0, 16);
          e = s + $urandom_range(0, 60);
        end
        default: begin
          s = $urandom;
          if (s > 32'hFFFF_FF00) s = s - 32'h100;
          e = s + $urandom_range(1, 40);
        end
      endcase
      write_region(s, e);
      if (!fresh_region || $urandom_range(0, 2) == 0) send_clear();
      load_sorted(REQ_LOAD_UNKNOWN, s - 32'd6, $urandom_range(0, 4), 5);
      load_sorted(REQ_LOAD_MASK, s - 32'd3, $urandom_range(0, 4), 5);
      stream_region(1'b1);
    end
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_REGION_START;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_CLEAR;
    req_if.interval_start <= '0;
    req_if.interval_end <= '0;
    req_if.packed_byte <= '0;
    req_if.last_byte <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_decode();
    test_count_errors();
    test_region_extremes();
    test_table_overflow();
    test_random_regions(55);

    wait_drain();
    if (err_count == 0 && expected_bases.size() == 0) begin
      $display("twobit_dna_unpacker_core test passed");
    end else begin
      $display("twobit_dna_unpacker_core test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tdu_pkg.sv
rtl/tdu_if.sv
rtl/tdu_table.sv
rtl/tdu_datapath.sv
rtl/tdu_ctrl.sv
rtl/twobit_dna_unpacker_core.sv
tb/twobit_dna_unpacker_core_tb.sv
